// ===== design/ssoe_pkg.sv =====
`timescale 1ns / 1ps
package ssoe_pkg;

    localparam int ACTION_W = 4;
    localparam int SEL_W    = 2;
    localparam int IO_W     = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_MEMBER     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_SUBSET     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_UNION      = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_INTERSECT  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_COMPLEMENT = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_DIFF       = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_SYMDIFF    = 4'd8;
    // codes above the last defined action are unknown
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_MIN = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_MAX = 4'd15;

    localparam logic [SEL_W-1:0] SEL_A    = 2'd0;
    localparam logic [SEL_W-1:0] SEL_B    = 2'd1;
    localparam logic [SEL_W-1:0] SEL_U    = 2'd2;
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SEL_W-1:0]    set_sel;
        logic signed [IO_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [IO_W-1:0] elem;
        logic                   answer;
        logic                   empty_res;
        logic                   last;
        logic [STATUS_W-1:0]    status;
    } res_t;

endpackage

// ===== design/ssoe_ram.sv =====
`timescale 1ns / 1ps
module ssoe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/small_set_operation_engine_top.sv =====
`timescale 1ns / 1ps
// Set engine: holds sets A, B and U (up to SET_CAPACITY distinct words each,
// insertion order) in three single-port-read RAMs.
// Input channel s_*: one request = action, set_sel, value.
// Output channel m_*: one or more result items per request; last marks the end.
// Each request runs a sequencer that scans the RAMs one word per cycle:
// an outer element is fetched, then the other set is scanned for it.
// Clear and unknown codes go straight to the final item; insert/member scan
// the target set once; subset and the streams scan the other set for each
// outer element (union: all of A, then B against A), one read per RAM port
// at a time. One request at a time.
// Reset clears the three counts (sets empty); RAM contents are not cleared.
// When the receiver stalls, the scan holds until the result register is
// taken; the next request is accepted once the current one has finished.
module small_set_operation_engine_top
    import ssoe_pkg::*;
#(
    parameter int SET_CAPACITY = 32,
    parameter int ELEM_WIDTH   = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);
    localparam int AW = $clog2(SET_CAPACITY);
    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OUTER = 3'd1; // issue outer read
    localparam logic [2:0] S_OWAIT = 3'd2; // outer data arrives
    localparam logic [2:0] S_INNER = 3'd3; // scan other set
    localparam logic [2:0] S_DONE  = 3'd4; // decide emit for outer elem
    localparam logic [2:0] S_FIN   = 3'd5; // final item

    // pass codes: which source is scanned against which
    localparam logic [2:0] P_A_ALL = 3'd0; // A unconditionally
    localparam logic [2:0] P_A_B   = 3'd1; // A vs B
    localparam logic [2:0] P_B_A   = 3'd2; // B vs A
    localparam logic [2:0] P_U_A   = 3'd3; // U vs A
    localparam logic [2:0] P_X     = 3'd4; // value vs target set

    logic [2:0] state_reg, state_next;
    logic [2:0] pass_reg, pass_next;
    req_t req_reg, req_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next, cnt_u_reg, cnt_u_next;
    logic [CW-1:0] oi_reg, oi_next, ii_reg, ii_next;
    logic [ELEM_WIDTH-1:0] key_reg, key_next;
    logic found_reg, found_next;
    logic flag_reg, flag_next;     // subset answer
    logic have_reg, have_next;     // a pending element held in pend
    logic [ELEM_WIDTH-1:0] pend_reg, pend_next;
    logic m_valid_reg, m_valid_next;
    res_t m_data_reg, m_data_next;

    logic [ELEM_WIDTH-1:0] rd_a, rd_b, rd_u, v_elem;
    logic [AW-1:0] ra_a, ra_b, ra_u;
    logic we_a, we_b, we_u;
    logic [AW-1:0] waddr;

    assign v_elem = ELEM_WIDTH'($signed(s_data.value));

    // key_reg holds the inserted value for the whole insert request
    ssoe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(SET_CAPACITY)) u_ram_a (
        .aclk, .we(we_a), .waddr, .wdata(key_reg),
        .raddr(ra_a), .rdata(rd_a));
    ssoe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(SET_CAPACITY)) u_ram_b (
        .aclk, .we(we_b), .waddr, .wdata(key_reg),
        .raddr(ra_b), .rdata(rd_b));
    ssoe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(SET_CAPACITY)) u_ram_u (
        .aclk, .we(we_u), .waddr, .wdata(key_reg),
        .raddr(ra_u), .rdata(rd_u));

    function automatic res_t mk(input logic [ELEM_WIDTH-1:0] e, input logic ans,
                                input logic emp, input logic lst,
                                input logic [STATUS_W-1:0] st);
        res_t r;
        r.elem = IO_W'($signed(e));
        r.answer = ans;
        r.empty_res = emp;
        r.last = lst;
        r.status = st;
        return r;
    endfunction

    // source / other set for the current pass
    logic [CW-1:0] src_n, oth_n;
    logic [ELEM_WIDTH-1:0] src_d, oth_d;
    always_comb begin
        unique case (pass_reg)
            P_A_ALL, P_A_B: begin src_n = cnt_a_reg; src_d = rd_a; end
            P_B_A:          begin src_n = cnt_b_reg; src_d = rd_b; end
            P_U_A:          begin src_n = cnt_u_reg; src_d = rd_u; end
            default:        begin src_n = '0;        src_d = rd_a; end
        endcase
        unique case (pass_reg)
            P_A_B:       begin oth_n = cnt_b_reg; oth_d = rd_b; end
            P_B_A, P_U_A:begin oth_n = cnt_a_reg; oth_d = rd_a; end
            P_X: begin
                unique case (req_reg.set_sel)
                    SEL_B:   begin oth_n = cnt_b_reg; oth_d = rd_b; end
                    SEL_U:   begin oth_n = cnt_u_reg; oth_d = rd_u; end
                    default: begin oth_n = cnt_a_reg; oth_d = rd_a; end
                endcase
            end
            default:     begin oth_n = '0;        oth_d = rd_a; end
        endcase
    end

    // read addresses: outer index in OUTER, inner index otherwise
    logic src_on_a, src_on_b, src_on_u;
    always_comb begin
        src_on_a = (pass_reg == P_A_ALL) || (pass_reg == P_A_B);
        src_on_b = (pass_reg == P_B_A);
        src_on_u = (pass_reg == P_U_A);
        ra_a = (state_reg == S_OUTER && src_on_a) ? oi_reg[AW-1:0] : ii_reg[AW-1:0];
        ra_b = (state_reg == S_OUTER && src_on_b) ? oi_reg[AW-1:0] : ii_reg[AW-1:0];
        ra_u = (state_reg == S_OUTER && src_on_u) ? oi_reg[AW-1:0] : ii_reg[AW-1:0];
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // insert write, done in S_FIN of an insert pass
    logic ins_go;
    assign ins_go = (state_reg == S_FIN) && (pass_reg == P_X) && out_free
                    && (req_reg.action == ACT_INSERT) && !found_reg && (oth_n < CAP);
    assign waddr = oth_n[AW-1:0];
    assign we_a = ins_go && (req_reg.set_sel == SEL_A);
    assign we_b = ins_go && (req_reg.set_sel == SEL_B);
    assign we_u = ins_go && (req_reg.set_sel == SEL_U);

    // does the held outer element qualify for emission
    logic keep;
    always_comb begin
        unique case (pass_reg)
            P_A_ALL: keep = 1'b1;
            P_A_B:   keep = (req_reg.action == ACT_INTERSECT) ? found_reg : !found_reg;
            default: keep = !found_reg;
        endcase
    end

    // next pass after the current one ends, or P_X when the run is over
    logic [2:0] follow;
    always_comb begin
        follow = P_X;
        if (req_reg.action == ACT_UNION && pass_reg == P_A_ALL) follow = P_B_A;
        if (req_reg.action == ACT_SYMDIFF && pass_reg == P_A_B) follow = P_B_A;
    end

    always_comb begin
        state_next = state_reg; pass_next = pass_reg; req_next = req_reg;
        cnt_a_next = cnt_a_reg; cnt_b_next = cnt_b_reg; cnt_u_next = cnt_u_reg;
        oi_next = oi_reg; ii_next = ii_reg; key_next = key_reg;
        found_next = found_reg; flag_next = flag_reg;
        have_next = have_reg; pend_next = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                req_next = s_data;
                req_next.value = IO_W'(v_elem);
                key_next = '0; oi_next = '0; ii_next = '0;
                found_next = 1'b0; flag_next = 1'b0; have_next = 1'b0;
                pass_next = P_X;
                priority case (s_data.action)
                    ACT_CLEAR: begin
                        state_next = S_FIN;
                        if (s_data.set_sel == SEL_A) cnt_a_next = '0;
                        if (s_data.set_sel == SEL_B) cnt_b_next = '0;
                        if (s_data.set_sel == SEL_U) cnt_u_next = '0;
                    end
                    ACT_INSERT, ACT_MEMBER: begin
                        state_next = S_INNER;
                        key_next = v_elem;
                        if (s_data.action == ACT_MEMBER) req_next.set_sel = SEL_A;
                    end
                    ACT_SUBSET: begin
                        pass_next = P_A_B; flag_next = 1'b1; state_next = S_OUTER;
                    end
                    ACT_UNION:      begin pass_next = P_A_ALL; state_next = S_OUTER; end
                    ACT_INTERSECT:  begin pass_next = P_A_B;   state_next = S_OUTER; end
                    ACT_COMPLEMENT: begin pass_next = P_U_A;   state_next = S_OUTER; end
                    ACT_DIFF: begin
                        pass_next = (s_data.set_sel == SEL_B) ? P_B_A : P_A_B;
                        state_next = S_OUTER;
                    end
                    ACT_SYMDIFF:    begin pass_next = P_A_B;   state_next = S_OUTER; end
                    default: state_next = S_FIN;
                endcase
            end
            S_OUTER: begin
                if (oi_reg >= src_n) begin
                    if (follow == P_X) begin
                        state_next = S_FIN;
                    end else begin
                        pass_next = follow; oi_next = '0;
                    end
                end else begin
                    state_next = S_OWAIT;
                end
            end
            S_OWAIT: begin
                key_next = src_d; ii_next = '0; found_next = 1'b0;
                state_next = (pass_reg == P_A_ALL) ? S_DONE : S_INNER;
            end
            S_INNER: begin
                // ii_reg addresses the RAM; data for ii_reg-1 is valid
                if (ii_reg != '0 && oth_d == key_reg) found_next = 1'b1;
                if (ii_reg >= oth_n || found_next) begin
                    state_next = (pass_reg == P_X) ? S_FIN : S_DONE;
                end else begin
                    ii_next = ii_reg + 1'b1;
                end
                if (ii_reg < oth_n && !found_next) ii_next = ii_reg + 1'b1;
                else if (!(ii_reg >= oth_n || found_next)) ii_next = ii_reg;
                if (!(ii_reg >= oth_n || found_next) || ii_reg < oth_n) begin
                    if (!found_next && ii_reg < oth_n) state_next = S_INNER;
                end
            end
            S_DONE: begin
                // one-deep hold so the final emitted item can carry last
                if (req_reg.action == ACT_SUBSET) begin
                    if (!found_reg) flag_next = 1'b0;
                    oi_next = oi_reg + 1'b1; state_next = S_OUTER;
                end else if (!keep) begin
                    oi_next = oi_reg + 1'b1; state_next = S_OUTER;
                end else if (!have_reg) begin
                    have_next = 1'b1; pend_next = key_reg;
                    oi_next = oi_reg + 1'b1; state_next = S_OUTER;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = mk(pend_reg, 1'b0, 1'b0, 1'b0, ST_OK);
                    pend_next = key_reg;
                    oi_next = oi_reg + 1'b1; state_next = S_OUTER;
                end
            end
            S_FIN: if (out_free) begin
                m_valid_next = 1'b1;
                state_next = S_IDLE;
                priority case (req_reg.action)
                    ACT_CLEAR: m_data_next = mk('0, 1'b0, 1'b1, 1'b1, ST_OK);
                    ACT_INSERT: begin
                        if (req_reg.set_sel == SEL_NONE || found_reg || oth_n < CAP)
                            m_data_next = mk('0, 1'b0, 1'b1, 1'b1, ST_OK);
                        else
                            m_data_next = mk('0, 1'b0, 1'b1, 1'b1, ST_FULL);
                        if (ins_go) begin
                            if (req_reg.set_sel == SEL_A) cnt_a_next = cnt_a_reg + 1'b1;
                            if (req_reg.set_sel == SEL_B) cnt_b_next = cnt_b_reg + 1'b1;
                            if (req_reg.set_sel == SEL_U) cnt_u_next = cnt_u_reg + 1'b1;
                        end
                    end
                    ACT_MEMBER: m_data_next = mk('0, found_reg, 1'b1, 1'b1, ST_OK);
                    ACT_SUBSET: m_data_next = mk('0, flag_reg, 1'b1, 1'b1, ST_OK);
                    ACT_UNION, ACT_INTERSECT, ACT_COMPLEMENT, ACT_DIFF, ACT_SYMDIFF:
                        m_data_next = have_reg ? mk(pend_reg, 1'b0, 1'b0, 1'b1, ST_OK)
                                               : mk('0, 1'b0, 1'b1, 1'b1, ST_OK);
                    default: m_data_next = mk('0, 1'b0, 1'b1, 1'b1, ST_UNKNOWN);
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            cnt_a_reg <= '0; cnt_b_reg <= '0; cnt_u_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_a_reg <= cnt_a_next; cnt_b_reg <= cnt_b_next; cnt_u_reg <= cnt_u_next;
        end
        pass_reg <= pass_next; req_reg <= req_next;
        oi_reg <= oi_next; ii_reg <= ii_next; key_reg <= key_next;
        found_reg <= found_next; flag_reg <= flag_next;
        have_reg <= have_next; pend_reg <= pend_next;
        m_data_reg <= m_data_next;
    end

    a_cnt_a: assert property (@(posedge aclk) disable iff (!aresetn) cnt_a_reg <= CAP)
        else $error("set A count over capacity");
    a_cnt_b: assert property (@(posedge aclk) disable iff (!aresetn) cnt_b_reg <= CAP)
        else $error("set B count over capacity");
    a_one_we: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({we_a, we_b, we_u}))
        else $error("more than one set written");
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE)
        else $error("request taken while busy");
endmodule

// ===== tb/small_set_operation_engine_top_tb.sv =====
`timescale 1ns / 1ps
module small_set_operation_engine_top_tb;
    import ssoe_pkg::*;

    localparam int CAP = 32;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    res_t m_data;
    logic s_ready_seen;

    small_set_operation_engine_top #(.SET_CAPACITY(CAP), .ELEM_WIDTH(32)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic signed [31:0] pa [CAP];
    logic signed [31:0] pb [CAP];
    logic signed [31:0] pu [CAP];
    int na, nb, nu;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   err_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic stim_done;
    // values that tend to repeat, so duplicates and hits are common
    logic signed [31:0] value_pool[$];

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit in_a(logic signed [31:0] v);
        for (int i = 0; i < na; i++) if (pa[i] == v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit in_b(logic signed [31:0] v);
        for (int i = 0; i < nb; i++) if (pb[i] == v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit in_u(logic signed [31:0] v);
        for (int i = 0; i < nu; i++) if (pu[i] == v) return 1'b1;
        return 1'b0;
    endfunction

    task automatic push_res(logic signed [31:0] e, logic ans, logic emp, logic lst,
                            logic [STATUS_W-1:0] st);
        res_t r;
        r.elem = e;
        r.answer = ans;
        r.empty_res = emp;
        r.last = lst;
        r.status = st;
        expected_results.push_back(r);
    endtask

    task automatic push_elem(logic signed [31:0] e, ref int k);
        push_res(e, 1'b0, 1'b0, 1'b0, ST_OK);
        k++;
    endtask

    task automatic close_stream(int k);
        res_t r;
        if (k == 0) begin
            push_res('0, 1'b0, 1'b1, 1'b1, ST_OK);
        end else begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic predict_set_op(req_t q);
        int k;
        bit yes;
        logic signed [31:0] v;
        k = 0;
        v = q.value;
        case (q.action)
            ACT_CLEAR: begin
                if (q.set_sel == SEL_A) na = 0;
                else if (q.set_sel == SEL_B) nb = 0;
                else if (q.set_sel == SEL_U) nu = 0;
                push_res('0, 1'b0, 1'b1, 1'b1, ST_OK);
            end
            ACT_INSERT: begin
                if (q.set_sel == SEL_A && !in_a(v)) begin
                    if (na >= CAP) begin
                        push_res('0, 1'b0, 1'b1, 1'b1, ST_FULL);
                        return;
                    end
                    pa[na] = v;
                    na++;
                end else if (q.set_sel == SEL_B && !in_b(v)) begin
                    if (nb >= CAP) begin
                        push_res('0, 1'b0, 1'b1, 1'b1, ST_FULL);
                        return;
                    end
                    pb[nb] = v;
                    nb++;
                end else if (q.set_sel == SEL_U && !in_u(v)) begin
                    if (nu >= CAP) begin
                        push_res('0, 1'b0, 1'b1, 1'b1, ST_FULL);
                        return;
                    end
                    pu[nu] = v;
                    nu++;
                end
                push_res('0, 1'b0, 1'b1, 1'b1, ST_OK);
            end
            ACT_MEMBER: push_res('0, in_a(v), 1'b1, 1'b1, ST_OK);
            ACT_SUBSET: begin
                yes = 1'b1;
                for (int i = 0; i < na; i++) if (!in_b(pa[i])) yes = 1'b0;
                push_res('0, yes, 1'b1, 1'b1, ST_OK);
            end
            ACT_UNION: begin
                for (int i = 0; i < na; i++) push_elem(pa[i], k);
                for (int i = 0; i < nb; i++) if (!in_a(pb[i])) push_elem(pb[i], k);
                close_stream(k);
            end
            ACT_INTERSECT: begin
                for (int i = 0; i < na; i++) if (in_b(pa[i])) push_elem(pa[i], k);
                close_stream(k);
            end
            ACT_COMPLEMENT: begin
                for (int i = 0; i < nu; i++) if (!in_a(pu[i])) push_elem(pu[i], k);
                close_stream(k);
            end
            ACT_DIFF: begin
                if (q.set_sel == SEL_B) begin
                    for (int i = 0; i < nb; i++) if (!in_a(pb[i])) push_elem(pb[i], k);
                end else begin
                    for (int i = 0; i < na; i++) if (!in_b(pa[i])) push_elem(pa[i], k);
                end
                close_stream(k);
            end
            ACT_SYMDIFF: begin
                for (int i = 0; i < na; i++) if (!in_b(pa[i])) push_elem(pa[i], k);
                for (int i = 0; i < nb; i++) if (!in_a(pb[i])) push_elem(pb[i], k);
                close_stream(k);
            end
            default: push_res('0, 1'b0, 1'b1, 1'b1, ST_UNKNOWN);
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        err_count++;
    endtask

    function automatic req_t mk(logic [ACTION_W-1:0] a, logic [SEL_W-1:0] s,
                                logic signed [31:0] v);
        req_t q;
        q.action = a;
        q.set_sel = s;
        q.value = v;
        return q;
    endfunction

    function automatic logic signed [31:0] pick_value();
        if (value_pool.size() > 0 && $urandom_range(0, 99) < 70)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // driver: requests change at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: sample at the rising edge; accepted requests feed the predictor
    always @(posedge aclk) begin
        res_t want;
        s_ready_seen <= 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_set_op(s_data);
                s_ready_seen <= 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_data.elem, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.elem !== want.elem)
                        report_mismatch("elem", m_data.elem, want.elem);
                    if (m_data.answer !== want.answer)
                        report_mismatch("answer", 32'(m_data.answer), 32'(want.answer));
                    if (m_data.empty_res !== want.empty_res)
                        report_mismatch("empty_res", 32'(m_data.empty_res),
                                        32'(want.empty_res));
                    if (m_data.last !== want.last)
                        report_mismatch("last", 32'(m_data.last), 32'(want.last));
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    task automatic add_random_phase(int n_items);
        req_t q;
        int r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                q = mk(ACT_INSERT, SEL_W'($urandom_range(SEL_A, SEL_NONE)), pick_value());
                if (value_pool.size() < 24) value_pool.push_back(q.value);
            end else if (r < 50) begin
                q = mk(ACT_CLEAR, SEL_W'($urandom_range(SEL_A, SEL_NONE)), $urandom);
            end else if (r < 95) begin
                q = mk(ACTION_W'($urandom_range(ACT_MEMBER, ACT_SYMDIFF)),
                       SEL_W'($urandom_range(SEL_A, SEL_NONE)), pick_value());
            end else begin
                q = mk(ACTION_W'($urandom_range(ACT_UNKNOWN_MIN, ACT_UNKNOWN_MAX)),
                       SEL_W'($urandom_range(SEL_A, SEL_NONE)), $urandom);
            end
            pending_reqs.push_back(q);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        s_ready_seen = 1'b0;
        err_count = 0;
        send_idle_pct = 12;
        recv_idle_pct = 62;
        stim_done = 1'b0;
        na = 0;
        nb = 0;
        nu = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty streams, extremes, duplicates, no-set, unknown
        pending_reqs.push_back(mk(ACT_UNION, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_SUBSET, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_A, 32'sh8000_0000));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_A, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_A, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_B, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_B, -1));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_U, 0));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_U, 32'sh8000_0000));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_NONE, 5));
        pending_reqs.push_back(mk(ACT_MEMBER, SEL_A, 32'sh8000_0000));
        pending_reqs.push_back(mk(ACT_MEMBER, SEL_A, -1));
        pending_reqs.push_back(mk(ACT_SUBSET, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_UNION, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_INTERSECT, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_COMPLEMENT, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_DIFF, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_DIFF, SEL_B, 0));
        pending_reqs.push_back(mk(ACT_DIFF, SEL_NONE, 0));
        pending_reqs.push_back(mk(ACT_SYMDIFF, SEL_NONE, 0));
        pending_reqs.push_back(mk(ACT_UNKNOWN_MIN, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_UNKNOWN_MAX, SEL_NONE, -1));
        pending_reqs.push_back(mk(ACT_CLEAR, SEL_NONE, 0));
        pending_reqs.push_back(mk(ACT_CLEAR, SEL_B, 0));
        pending_reqs.push_back(mk(ACT_SUBSET, SEL_A, 0));
        // fill U past capacity: full flag, then a duplicate when full
        for (int i = 0; i < CAP; i++) pending_reqs.push_back(mk(ACT_INSERT, SEL_U, i + 100));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_U, 7));
        pending_reqs.push_back(mk(ACT_INSERT, SEL_U, 100));
        pending_reqs.push_back(mk(ACT_COMPLEMENT, SEL_A, 0));
        pending_reqs.push_back(mk(ACT_CLEAR, SEL_U, 0));
        wait_drained();

        add_random_phase(40);
        wait_drained();
        send_idle_pct = 62;
        recv_idle_pct = 12;
        add_random_phase(35);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_phase(35);
        wait_drained();
        repeat (200) @(posedge aclk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done === 1'b1);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ssoe_pkg.sv
design/ssoe_ram.sv
design/small_set_operation_engine_top.sv
tb/small_set_operation_engine_top_tb.sv
